// ===== src/idle_dimming_backlight_fader_core_defines.svh =====
// Shared assertion macros for the backlight fader checks.
`ifndef IDLE_DIMMING_BACKLIGHT_FADER_CORE_DEFINES_SVH
`define IDLE_DIMMING_BACKLIGHT_FADER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDBF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("idbf check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IDBF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("idbf check failed");

`endif

// ===== src/idbf_pkg.sv =====
package idbf_pkg;

  localparam int LEVEL_W   = 7;
  localparam int FADE_W    = 20;
  localparam int IDLE_W    = 32;
  localparam int TYPE_W    = 5;
  localparam int CODE_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int DIV_CNT_W = $clog2(FADE_W);

  localparam logic [LEVEL_W-1:0] MAX_LEVEL       = LEVEL_W'(100);
  localparam logic [LEVEL_W-1:0] ON_LEVEL_RST    = LEVEL_W'(30);
  localparam logic [FADE_W-1:0]  FADE_TICKS_RST  = FADE_W'(100000);
  localparam logic [IDLE_W-1:0]  IDLE_TICKS_RST  = IDLE_W'(10000000);

  localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_TICKS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS = CFG_IDX_W'(2);

  localparam logic [TYPE_W-1:0] EV_SYNC = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] EV_KEY  = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] EV_ABS  = TYPE_W'(3);
  localparam logic [TYPE_W-1:0] EV_MSC  = TYPE_W'(4);
  localparam logic [CODE_W-1:0] CODE_LOST = CODE_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== src/idle_dimming_backlight_fader_core.sv =====
// Idle-dimming backlight fader. Each beat on the input is one time tick
// (action 0) or one input event (action 1); each produces exactly one result
// beat with the present level, whether the target is lit, and whether the
// level stepped. An event beat or a tick that keeps its target goes from
// acceptance to the ST_DONE state and is written to the output register
// from there once that register is free. A tick that moves the target by a
// nonzero distance runs the step-interval division through a bit-serial
// restoring divider that retires one quotient bit per cycle, in the ST_DIV
// state, before it passes through ST_DONE. One item is in work at a time;
// the next beat is accepted as soon as the previous result sits in the
// output register, even if the sink has not yet taken it. Configuration
// writes apply at once and are meant for idle periods.
module idle_dimming_backlight_fader_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [idbf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [idbf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [idbf_pkg::TYPE_W-1:0]     event_type_i,
  input  logic [idbf_pkg::CODE_W-1:0]     event_code_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [idbf_pkg::LEVEL_W-1:0]    level_now_o,
  output logic                            lit_target_o,
  output logic                            level_changed_o
);
  import idbf_pkg::*;

  state_e state_q, state_d;

  logic [LEVEL_W-1:0]   on_level_q;
  logic [FADE_W-1:0]    fade_ticks_q;
  logic [IDLE_W-1:0]    idle_ticks_q;

  logic [IDLE_W-1:0]    idle_cnt_q, idle_cnt_d;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic [LEVEL_W-1:0]   target_q, target_d;
  logic [FADE_W-1:0]    step_int_q, step_int_d;
  logic [FADE_W-1:0]    step_cnt_q, step_cnt_d;
  logic                 chg_q, chg_d;

  logic [FADE_W-1:0]    div_q, div_d;
  logic [LEVEL_W-1:0]   rem_q, rem_d;
  logic [LEVEL_W-1:0]   dist_q, dist_d;
  logic [DIV_CNT_W-1:0] bit_cnt_q, bit_cnt_d;

  logic                 out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]   out_level_q, out_level_d;
  logic                 out_lit_q, out_lit_d;
  logic                 out_chg_q, out_chg_d;

  logic                 in_fire;
  logic                 qualify;
  logic [LEVEL_W-1:0]   lit_level;
  logic [IDLE_W-1:0]    idle_dec;
  logic [LEVEL_W-1:0]   want;
  logic [LEVEL_W-1:0]   lvl_gap;
  logic [FADE_W-1:0]    sc_dec;
  logic [LEVEL_W-1:0]   level_step;
  logic [LEVEL_W:0]     rem_sh;
  logic                 rem_ge;
  logic [FADE_W-1:0]    quot;
  logic [FADE_W-1:0]    interval;

  assign in_ready_o      = (state_q == ST_IDLE);
  assign in_fire         = in_valid_i && in_ready_o;
  assign out_valid_o     = out_valid_q;
  assign level_now_o     = out_level_q;
  assign lit_target_o    = out_lit_q;
  assign level_changed_o = out_chg_q;

  assign qualify = (event_type_i == EV_KEY) || (event_type_i == EV_ABS) ||
                   (event_type_i == EV_MSC) ||
                   ((event_type_i == EV_SYNC) && (event_code_i == CODE_LOST));
  assign lit_level  = (on_level_q > MAX_LEVEL) ? MAX_LEVEL : on_level_q;
  assign idle_dec   = (idle_cnt_q != '0) ? idle_cnt_q - IDLE_W'(1) : idle_cnt_q;
  assign want       = (idle_dec != '0) ? lit_level : '0;
  assign lvl_gap    = (level_q > want) ? level_q - want : want - level_q;
  assign sc_dec     = (step_cnt_q != '0) ? step_cnt_q - FADE_W'(1) : step_cnt_q;
  assign level_step = (level_q < target_q) ? level_q + LEVEL_W'(1)
                                           : level_q - LEVEL_W'(1);

  assign rem_sh   = {rem_q, div_q[FADE_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, dist_q});
  assign quot     = {div_q[FADE_W-2:0], rem_ge};
  assign interval = (quot == '0) ? FADE_W'(1) : quot;

  always_comb begin
    state_d     = state_q;
    idle_cnt_d  = idle_cnt_q;
    level_d     = level_q;
    target_d    = target_q;
    step_int_d  = step_int_q;
    step_cnt_d  = step_cnt_q;
    chg_d       = chg_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dist_d      = dist_q;
    bit_cnt_d   = bit_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_level_d = out_level_q;
    out_lit_d   = out_lit_q;
    out_chg_d   = out_chg_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          chg_d   = 1'b0;
          state_d = ST_DONE;
          if (action_i) begin
            if (qualify) begin
              idle_cnt_d = idle_ticks_q;
            end
          end else begin
            idle_cnt_d = idle_dec;
            if (want != target_q) begin
              target_d = want;
              if (lvl_gap == '0) begin
                step_cnt_d = '0;
              end else begin
                dist_d    = lvl_gap;
                div_d     = fade_ticks_q;
                rem_d     = '0;
                bit_cnt_d = '0;
                state_d   = ST_DIV;
              end
            end else if (level_q != target_q) begin
              if (sc_dec == '0) begin
                level_d    = level_step;
                step_cnt_d = (level_step == target_q) ? '0 : step_int_q;
                chg_d      = 1'b1;
              end else begin
                step_cnt_d = sc_dec;
              end
            end else begin
              step_cnt_d = '0;
            end
          end
        end
      end
      ST_DIV: begin
        rem_d     = rem_ge ? LEVEL_W'(rem_sh - {1'b0, dist_q}) : rem_sh[LEVEL_W-1:0];
        div_d     = quot;
        bit_cnt_d = bit_cnt_q + DIV_CNT_W'(1);
        if (bit_cnt_q == DIV_CNT_W'(FADE_W - 1)) begin
          step_int_d = interval;
          level_d    = level_step;
          step_cnt_d = (level_step == target_q) ? '0 : interval;
          chg_d      = 1'b1;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_level_d = level_q;
          out_lit_d   = (target_q != '0);
          out_chg_d   = chg_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_level_q   <= ON_LEVEL_RST;
      fade_ticks_q <= FADE_TICKS_RST;
      idle_ticks_q <= IDLE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ON_LEVEL:   on_level_q   <= cfg_data_i[LEVEL_W-1:0];
        CFG_FADE_TICKS: fade_ticks_q <= cfg_data_i[FADE_W-1:0];
        CFG_IDLE_TICKS: idle_ticks_q <= cfg_data_i[IDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idle_cnt_q  <= '0;
      level_q     <= '0;
      target_q    <= '0;
      step_int_q  <= '0;
      step_cnt_q  <= '0;
      chg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idle_cnt_q  <= idle_cnt_d;
      level_q     <= level_d;
      target_q    <= target_d;
      step_int_q  <= step_int_d;
      step_cnt_q  <= step_cnt_d;
      chg_q       <= chg_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q       <= div_d;
    rem_q       <= rem_d;
    dist_q      <= dist_d;
    out_level_q <= out_level_d;
    out_lit_q   <= out_lit_d;
    out_chg_q   <= out_chg_d;
  end

endmodule

// ===== src/idbf_checker.sv =====
`include "idle_dimming_backlight_fader_core_defines.svh"

module idbf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [idbf_pkg::LEVEL_W-1:0]   level_now_o
);
  import idbf_pkg::*;

  // A waiting result beat holds until it is taken.
  `IDBF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `IDBF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(level_now_o))
  // One item is in work at a time.
  `IDBF_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // The level never exceeds the top brightness.
  `IDBF_ASSERT_NOW(a_level_max, clk_i, rst_ni, out_valid_o, level_now_o <= MAX_LEVEL)

endmodule

bind idle_dimming_backlight_fader_core idbf_checker u_idbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .level_now_o (level_now_o)
);
